FILE: hw/rtl/b3m_pkg.sv
package b3m_pkg;

   localparam int unsigned MAX_WIDTH  = 2048;
   localparam int unsigned MAX_HEIGHT = 2048;

   localparam int unsigned SIZE_W  = 12;
   localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT + 4);
   localparam int unsigned COUNT_W = 23;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE        = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THIN_DIRECTION = 8'd3;

   localparam logic [1:0] MODE_THIN   = 2'd0;
   localparam logic [1:0] MODE_ERODE  = 2'd1;
   localparam logic [1:0] MODE_DILATE = 2'd2;
   localparam logic [1:0] MODE_PRUNE  = 2'd3;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_WEST  = 2'd2;
   localparam logic [1:0] DIR_EAST  = 2'd3;

   localparam logic [8:0] SIDE_NORTH = 9'o200;
   localparam logic [8:0] SIDE_SOUTH = 9'o002;
   localparam logic [8:0] SIDE_WEST  = 9'o040;
   localparam logic [8:0] SIDE_EAST  = 9'o010;

   typedef logic [31:0] rom_type [16];

   localparam rom_type ROM_THIN = '{
      32'h88000000, 32'h80C00000, 32'h88000000, 32'h80C00000,
      32'h00000000, 32'h00000000, 32'hBB000000, 32'h00000000,
      32'h88000000, 32'h80C00000, 32'h88000000, 32'h80C00000,
      32'h00000000, 32'h00F30000, 32'hBB000000, 32'h33F30000};
   localparam rom_type ROM_ERODE = '{
      32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000,
      32'hFFFF0000, 32'h33FF0000, 32'hFFFF0000, 32'h33FF0000,
      32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000,
      32'hFFFF0000, 32'h33FF0000, 32'hFFFF0000, 32'h33FF0000};
   localparam rom_type ROM_DILATE = '{
      32'h0000FFCC, 32'h0000FFFF, 32'h0000FFCC, 32'h0000FFFF,
      32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
      32'h0000FFCC, 32'h0000FFFF, 32'h0000FFCC, 32'h0000FFFF,
      32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF};
   localparam rom_type ROM_PRUNE = '{
      32'h33CC0000, 32'h00330000, 32'h33CC0000, 32'h00330000,
      32'h00330000, 32'h00000000, 32'h00330000, 32'h00000000,
      32'h33CC0000, 32'h00330000, 32'h33CC0000, 32'h00330000,
      32'h00330000, 32'h00000000, 32'h00330000, 32'h00000000};

   typedef struct packed {
      logic             pix;
      logic             row_zero;
      logic             row_one;
      logic             col_zero;
      logic             valid;
      logic             last;
      logic             restart;
      logic [COL_W-1:0] addr;
   } stage_type;

   function automatic logic [8:0] side_mask(input logic [1:0] dir);
      logic [8:0] m;
      unique case (dir)
         DIR_NORTH: m = SIDE_NORTH;
         DIR_SOUTH: m = SIDE_SOUTH;
         DIR_WEST:  m = SIDE_WEST;
         DIR_EAST:  m = SIDE_EAST;
         default:   m = SIDE_NORTH;
      endcase
      return m;
   endfunction

   function automatic logic rom_bit(input logic [1:0] mode, input logic [8:0] idx);
      logic [31:0] word;
      unique case (mode)
         MODE_THIN:   word = ROM_THIN[idx[8:5]];
         MODE_ERODE:  word = ROM_ERODE[idx[8:5]];
         MODE_DILATE: word = ROM_DILATE[idx[8:5]];
         MODE_PRUNE:  word = ROM_PRUNE[idx[8:5]];
         default:     word = ROM_THIN[idx[8:5]];
      endcase
      return word[idx[4:0]];
   endfunction

endpackage

FILE: hw/rtl/b3m_ram.sv
module b3m_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/binary_3x3_morphology_pass_core.sv
// Binary 3x3 morphology pass over a raster-order pixel stream.
// req_* carries one pixel per beat (tdata bit 0) with tuser marking a flush
// beat; after the last pixel of a frame the host sends width+1 flush beats.
// rsp_* returns the new center pixel, a changed flag and the running hit
// count of the frame; tlast marks the bottom-right pixel of the frame.
// csr_* writes image_width, image_height, op_mode and thin_direction; write
// them only while the block is idle.
// Throughput: one beat per cycle unless a clearing pass runs or rsp_tready stalls.
// A beat is captured in the input stage together with its line store read, and
// the decision logic loads the output register when that stage advances; the
// result for pixel n follows the beat that completes its window (width+1 beats after pixel n).
// Reset: a synchronous reset clears the pipeline, then a clearing pass writes zero to all 2048
// line store entries; req_tready stays low during that pass while
// csr writes are taken.
// When the receiver holds rsp_tready low, the output register holds its
// beat, the decision stage fills, and req_tready drops until a beat leaves.
module binary_3x3_morphology_pass_core
   import b3m_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] pixel_in
   input  logic [0:0]            req_tuser,  // [0] flush
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] pixel_out, [1] changed, [24:2] change_count
   output logic                  rsp_tlast,  // last_pixel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_data
);

   localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] WIDTH_HI  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_HI = SIZE_W'(MAX_HEIGHT);
   localparam logic [COL_W-1:0]  CLR_LAST  = COL_W'(MAX_WIDTH - 1);

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [1:0]        mode_ff, dir_ff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              clr_busy_ff;
   logic [COL_W-1:0]  clr_addr_ff;

   logic              s1_valid_ff;
   stage_type         s1_ff, s1_in;
   logic [5:0]        wb_ff, wb_in;
   logic [COUNT_W-1:0] ht_ff, ht_in;

   logic              rsp_valid_ff;
   logic              rsp_pix_ff, rsp_chg_ff, rsp_last_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;

   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [ROW_W-1:0]  w_ext, h_ext;
   logic [COL_W-1:0]  c;
   logic [ROW_W-1:0]  r, crow, ccolpos;
   logic              req_fire, s1_fire;

   logic [1:0]        rd_data, stored;
   logic [2:0]        rcol, lcol, ccol, right;
   logic [8:0]        nbr;
   logic              hit, center;
   logic [COUNT_W-1:0] base, cnt;

   assign csr_ready = 1'b1;

   always_comb begin
      w_eff = (width_ff < SIZE_MIN) ? SIZE_MIN : ((width_ff > WIDTH_HI) ? WIDTH_HI : width_ff);
      h_eff = (height_ff < SIZE_MIN) ? SIZE_MIN :
              ((height_ff > HEIGHT_HI) ? HEIGHT_HI : height_ff);
      w_ext = ROW_W'(w_eff);
      h_ext = ROW_W'(h_eff);
   end

   // input stage: position tracking and line store read
   always_comb begin
      c       = col_ff;
      r       = row_ff;
      s1_in   = '0;
      crow    = '0;
      ccolpos = '0;
      if (ROW_W'(c) >= w_ext) begin
         c = '0;
         r = r + 1'b1;
      end
      if (r > h_ext + 1'b1) begin
         r = '0;
         c = '0;
         s1_in.restart = 1'b1;
      end
      s1_in.pix      = req_tdata[0] & ~req_tuser[0] & (r < h_ext);
      s1_in.row_zero = (r == '0);
      s1_in.row_one  = (r == ROW_W'(1));
      s1_in.col_zero = (c == '0);
      s1_in.addr     = c;
      if (c == '0) begin
         s1_in.valid = (r >= ROW_W'(2)) && ((r - ROW_W'(2)) < h_ext);
         crow        = r - ROW_W'(2);
         ccolpos     = w_ext - 1'b1;
      end else begin
         s1_in.valid = (r >= ROW_W'(1)) && ((r - ROW_W'(1)) < h_ext);
         crow        = r - ROW_W'(1);
         ccolpos     = ROW_W'(c) - 1'b1;
      end
      s1_in.last = s1_in.valid && (crow == h_ext - 1'b1) && (ccolpos == w_ext - 1'b1);
      if (ROW_W'(c) + 1'b1 >= w_ext) begin
         col_in = '0;
         row_in = r + 1'b1;
      end else begin
         col_in = c + 1'b1;
         row_in = r;
      end
      if (s1_in.last) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign s1_fire    = s1_valid_ff && (!s1_ff.valid || !rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_fire);
   assign req_fire   = req_tvalid && req_tready;

   // decision stage
   always_comb begin
      if (s1_ff.row_zero) begin
         stored = 2'b00;
      end else if (s1_ff.row_one) begin
         stored = {1'b0, rd_data[0]};
      end else begin
         stored = rd_data;
      end
      rcol  = {stored, s1_ff.pix};
      lcol  = wb_ff[5:3];
      ccol  = wb_ff[2:0];
      right = s1_ff.col_zero ? 3'b000 : rcol;
      wb_in = s1_ff.col_zero ? {3'b000, rcol} : {ccol, rcol};
      nbr   = {lcol[2], ccol[2], right[2], lcol[1], ccol[1], right[1],
               lcol[0], ccol[0], right[0]};
      center = nbr[4];
      if (mode_ff == MODE_THIN) begin
         hit = rom_bit(mode_ff, nbr) && ((nbr & side_mask(dir_ff)) == '0);
      end else begin
         hit = rom_bit(mode_ff, nbr);
      end
      base = s1_ff.restart ? '0 : ht_ff;
      cnt  = (hit && base != COUNT_MAX) ? base + 1'b1 : base;
      if (!s1_ff.valid) begin
         ht_in = base;
      end else if (s1_ff.last) begin
         ht_in = '0;
      end else begin
         ht_in = cnt;
      end
   end

   b3m_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (clr_busy_ff || s1_fire),
      .wr_addr (clr_busy_ff ? clr_addr_ff : s1_ff.addr),
      .wr_data (clr_busy_ff ? 2'b00 : {stored[0], s1_ff.pix}),
      .rd_en   (req_fire),
      .rd_addr (c),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_HI;
         height_ff <= HEIGHT_HI;
         mode_ff   <= MODE_THIN;
         dir_ff    <= DIR_NORTH;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:   height_ff <= csr_data;
            CSR_OP_MODE:        mode_ff   <= csr_data[1:0];
            CSR_THIN_DIRECTION: dir_ff    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= '0;
         ht_ff <= '0;
      end else if (s1_fire) begin
         wb_ff <= wb_in;
         ht_ff <= ht_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_ff.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.valid) begin
         rsp_pix_ff  <= hit ? (mode_ff == MODE_DILATE) : center;
         rsp_chg_ff  <= hit;
         rsp_last_ff <= s1_ff.last;
         rsp_cnt_ff  <= cnt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - COUNT_W - 2)'(0), rsp_cnt_ff, rsp_chg_ff, rsp_pix_ff};

endmodule

FILE: hw/rtl/b3m_checker.sv
module b3m_checker
   import b3m_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high during line store clearing");

   a_changed_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[24:2] != '0)
      else $error("changed beat with zero change count");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:25] == '0)
      else $error("rsp tdata padding not zero");

endmodule

bind binary_3x3_morphology_pass_core b3m_checker u_b3m_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
